[hdl/etm_pkg.sv]
`timescale 1ns / 1ps
package etm_pkg;

  localparam int unsigned TrigStagesDefault = 16;
  localparam int unsigned AtanLen = 24;
  localparam int unsigned AngW = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned TrigW = 34;

  localparam logic signed [17:0] FullTurn = 18'sd23040;
  localparam logic signed [17:0] HalfTurn = 18'sd11520;
  localparam logic signed [17:0] QuarterTurn = 18'sd5760;
  localparam logic signed [35:0] RadK = 36'sd19190098069;
  localparam logic signed [TrigW-1:0] CordicX0 = 34'sd652032874;
  localparam logic signed [TrigW-1:0] OneQ30 = 34'sd1073741824;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  function automatic trig_t atan_q30(input int unsigned i);
    trig_t v;
    begin
      case (i)
        0: v = 34'sd843314856;
        1: v = 34'sd497837829;
        2: v = 34'sd263043836;
        3: v = 34'sd133525158;
        4: v = 34'sd67021686;
        5: v = 34'sd33543515;
        6: v = 34'sd16775850;
        7: v = 34'sd8388437;
        8: v = 34'sd4194282;
        9: v = 34'sd2097149;
        10: v = 34'sd1048575;
        11: v = 34'sd524287;
        12: v = 34'sd262143;
        13: v = 34'sd131071;
        14: v = 34'sd65535;
        15: v = 34'sd32767;
        16: v = 34'sd16383;
        17: v = 34'sd8191;
        18: v = 34'sd4095;
        19: v = 34'sd2047;
        20: v = 34'sd1023;
        21: v = 34'sd511;
        22: v = 34'sd255;
        23: v = 34'sd127;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic trig_t mul30(input trig_t a, input trig_t b);
    logic signed [67:0] p;
    begin
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return TrigW'(p >>> 30);
    end
  endfunction

  function automatic trig_t clamp_one(input trig_t v);
    trig_t r;
    begin
      if (v > OneQ30) r = OneQ30;
      else if (v < -OneQ30) r = -OneQ30;
      else r = v;
      return r;
    end
  endfunction

endpackage

[hdl/etm_sincos.sv]
`timescale 1ns / 1ps
module etm_sincos #(
  parameter int unsigned TRIG_STAGES = etm_pkg::TrigStagesDefault
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [etm_pkg::AngW-1:0] angle_i,
  output etm_pkg::sincos_t            sc_o
);
  import etm_pkg::*;

  localparam int unsigned NSt = (TRIG_STAGES > AtanLen) ? AtanLen : TRIG_STAGES;

  logic signed [17:0] r_q;
  logic neg0_q;
  trig_t x_q [NSt+1];
  trig_t y_q [NSt+1];
  trig_t z_q [NSt+1];
  logic  n_q [NSt+1];
  sincos_t sc_q;

  logic signed [17:0] r_d;
  logic neg_d;
  logic signed [17:0] m;
  logic signed [55:0] prod;

  always_comb begin
    m = 18'(angle_i);
    if (m < 0) m = m + FullTurn;
    if (m < 0) m = m + FullTurn;
    if (m >= FullTurn) m = m - FullTurn;
    if (m > HalfTurn) m = m - FullTurn;
    neg_d = 1'b0;
    r_d = m;
    if (m > QuarterTurn) begin
      r_d = m - HalfTurn;
      neg_d = 1'b1;
    end else if (m < -QuarterTurn) begin
      r_d = m + HalfTurn;
      neg_d = 1'b1;
    end
    prod = 56'(r_q) * 56'(RadK) + 56'sd32768;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
      neg0_q <= neg_d;
      x_q[0] <= CordicX0;
      y_q[0] <= '0;
      z_q[0] <= TrigW'(prod >>> 16);
      n_q[0] <= neg0_q;
    end
  end

  for (genvar i = 0; i < NSt; i++) begin : g_st
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= n_q[i];
        if (!z_q[i][TrigW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_q30(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q.c <= n_q[NSt] ? -clamp_one(x_q[NSt]) : clamp_one(x_q[NSt]);
      sc_q.s <= n_q[NSt] ? -clamp_one(y_q[NSt]) : clamp_one(y_q[NSt]);
    end
  end

  assign sc_o = sc_q;

endmodule

[hdl/etm_matrix.sv]
`timescale 1ns / 1ps
module etm_matrix (
  input  logic             clk_i,
  input  logic             en_i,
  input  etm_pkg::sincos_t scx_i,
  input  etm_pkg::sincos_t scy_i,
  input  etm_pkg::sincos_t scz_i,
  input  etm_pkg::word_t   kx_i,
  input  etm_pkg::word_t   ky_i,
  input  etm_pkg::word_t   kz_i,
  output etm_pkg::word_t   m_o [9]
);
  import etm_pkg::*;

  trig_t sx1_q, cx1_q;
  trig_t czsy_q, szsy_q, czcy_q, szcy_q, szcx_q, szsx_q, czcx_q, czsx_q;
  trig_t cysx_q, cycx_q, nsy_q;
  trig_t r_q [9];
  word_t k1_q [3];
  word_t k2_q [3];
  word_t m_q [9];

  function automatic word_t scale_entry(input trig_t r, input word_t k);
    logic signed [66:0] p;
    logic signed [66:0] v;
    word_t o;
    begin
      p = 67'(r) * 67'(k) + 67'sd536870912;
      v = p >>> 30;
      if (v > 67'sd2147483647) o = 32'sh7fffffff;
      else if (v < -67'sd2147483648) o = 32'sh80000000;
      else o = WordW'(v);
      return o;
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx1_q <= scx_i.s;
      cx1_q <= scx_i.c;
      czsy_q <= mul30(scz_i.c, scy_i.s);
      szsy_q <= mul30(scz_i.s, scy_i.s);
      czcy_q <= mul30(scz_i.c, scy_i.c);
      szcy_q <= mul30(scz_i.s, scy_i.c);
      szcx_q <= mul30(scz_i.s, scx_i.c);
      szsx_q <= mul30(scz_i.s, scx_i.s);
      czcx_q <= mul30(scz_i.c, scx_i.c);
      czsx_q <= mul30(scz_i.c, scx_i.s);
      cysx_q <= mul30(scy_i.c, scx_i.s);
      cycx_q <= mul30(scy_i.c, scx_i.c);
      nsy_q <= -scy_i.s;
      k1_q[0] <= kx_i;
      k1_q[1] <= ky_i;
      k1_q[2] <= kz_i;
      r_q[0] <= czcy_q;
      r_q[1] <= szcy_q;
      r_q[2] <= nsy_q;
      r_q[3] <= mul30(czsy_q, sx1_q) - szcx_q;
      r_q[4] <= mul30(szsy_q, sx1_q) + czcx_q;
      r_q[5] <= cysx_q;
      r_q[6] <= mul30(czsy_q, cx1_q) + szsx_q;
      r_q[7] <= mul30(szsy_q, cx1_q) - czsx_q;
      r_q[8] <= cycx_q;
      k2_q <= k1_q;
      for (int i = 0; i < 9; i++) begin
        m_q[i] <= scale_entry(r_q[i], k2_q[i/3]);
      end
    end
  end

  assign m_o = m_q;

endmodule

[hdl/euler_trs_model_matrix.sv]
`timescale 1ns / 1ps
// Builds the twelve entries of the upper three rows of the model matrix T*R*S, with
// R = Rz*Ry*Rx from Euler angles in degrees (Q10.6); outputs are Q16.16 and the nine R*S
// entries saturate. One word is accepted every cycle while stall_o is low. The pipeline has
// two angle reduction stages, the CORDIC stage chain (stages beyond 24 are not built), one
// sign stage and three multiply stages. An output stall with valid_o high freezes it all.
module euler_trs_model_matrix #(
  parameter int unsigned TRIG_STAGES = etm_pkg::TrigStagesDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic signed [15:0]    angle_x_i,
  input  logic signed [15:0]    angle_y_i,
  input  logic signed [15:0]    angle_z_i,
  input  etm_pkg::word_t        pos_x_i,
  input  etm_pkg::word_t        pos_y_i,
  input  etm_pkg::word_t        pos_z_i,
  input  etm_pkg::word_t        scale_x_i,
  input  etm_pkg::word_t        scale_y_i,
  input  etm_pkg::word_t        scale_z_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output etm_pkg::word_t        m00_o,
  output etm_pkg::word_t        m10_o,
  output etm_pkg::word_t        m20_o,
  output etm_pkg::word_t        m01_o,
  output etm_pkg::word_t        m11_o,
  output etm_pkg::word_t        m21_o,
  output etm_pkg::word_t        m02_o,
  output etm_pkg::word_t        m12_o,
  output etm_pkg::word_t        m22_o,
  output etm_pkg::word_t        m03_o,
  output etm_pkg::word_t        m13_o,
  output etm_pkg::word_t        m23_o
);
  import etm_pkg::*;

  localparam int unsigned NSt = (TRIG_STAGES > AtanLen) ? AtanLen : TRIG_STAGES;
  localparam int unsigned TrigLat = NSt + 3;
  localparam int unsigned Lat = TrigLat + 3;

  logic en;
  logic vld_q [Lat];
  word_t px_q [Lat];
  word_t py_q [Lat];
  word_t pz_q [Lat];
  word_t kx_q [TrigLat];
  word_t ky_q [TrigLat];
  word_t kz_q [TrigLat];
  sincos_t scx, scy, scz;
  word_t m [9];

  assign en = !(vld_q[Lat-1] && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0] <= pos_x_i;
      py_q[0] <= pos_y_i;
      pz_q[0] <= pos_z_i;
      kx_q[0] <= scale_x_i;
      ky_q[0] <= scale_y_i;
      kz_q[0] <= scale_z_i;
      for (int i = 1; i < Lat; i++) begin
        px_q[i] <= px_q[i-1];
        py_q[i] <= py_q[i-1];
        pz_q[i] <= pz_q[i-1];
      end
      for (int i = 1; i < TrigLat; i++) begin
        kx_q[i] <= kx_q[i-1];
        ky_q[i] <= ky_q[i-1];
        kz_q[i] <= kz_q[i-1];
      end
    end
  end

  etm_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_sc_x (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_x_i), .sc_o(scx));
  etm_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_sc_y (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_y_i), .sc_o(scy));
  etm_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_sc_z (
    .clk_i(clk_i), .en_i(en), .angle_i(angle_z_i), .sc_o(scz));

  etm_matrix u_matrix (
    .clk_i(clk_i), .en_i(en), .scx_i(scx), .scy_i(scy), .scz_i(scz),
    .kx_i(kx_q[TrigLat-1]), .ky_i(ky_q[TrigLat-1]), .kz_i(kz_q[TrigLat-1]), .m_o(m));

  assign valid_o = vld_q[Lat-1];
  assign m00_o = m[0];
  assign m10_o = m[1];
  assign m20_o = m[2];
  assign m01_o = m[3];
  assign m11_o = m[4];
  assign m21_o = m[5];
  assign m02_o = m[6];
  assign m12_o = m[7];
  assign m22_o = m[8];
  assign m03_o = px_q[Lat-1];
  assign m13_o = py_q[Lat-1];
  assign m23_o = pz_q[Lat-1];

endmodule
